// ===== hdl/mcs_pkg.sv =====
// Package for the maximum clique search block: shared constants, the
// controller state type, command/status structs, the stack frame type and lowest_bit.
// No dependencies.
package mcs_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int ROW_SLOTS        = 32;
  localparam int ROW_W            = 32;
  localparam int IDX_W            = 5;
  localparam int CNT_W            = 6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_DESCEND,
    S_RESTORE,
    S_EMIT
  } mcs_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_row;
    logic start;
    logic eval;
    logic push;
    logic back;
    logic descend;
    logic restore;
    logic emit_load;
    logic emit_take;
  } mcs_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic has_cand;
    logic at_root;
    logic emit_last;
  } mcs_status_t;

  // One saved search level: chosen vertex and the candidates left behind it
  typedef struct packed {
    logic [IDX_W-1:0] vertex;
    logic [ROW_W-1:0] mask;
  } mcs_frame_t;

  // Index of the lowest set bit (zero when the mask is empty)
  function automatic logic [IDX_W-1:0] lowest_bit(input logic [ROW_W-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (m[k]) idx = IDX_W'(k);
    end
    return idx;
  endfunction

endpackage

// ===== hdl/mcs_datapath.sv =====
// Datapath of the maximum clique search: adjacency row memory, level stack
// memory, search registers and the result shift-out register.
// Depends on mcs_pkg.
module mcs_datapath #(
  parameter int MAX_VERTICES = mcs_pkg::MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mcs_pkg::mcs_ctrl_t       ctrl,
  output mcs_pkg::mcs_status_t     status,
  input  logic                     cfg_we,
  input  logic [mcs_pkg::CNT_W-1:0] cfg_data,
  input  logic [mcs_pkg::IDX_W-1:0] in_row_index,
  input  logic [mcs_pkg::ROW_W-1:0] in_row_bits,
  output logic [mcs_pkg::IDX_W-1:0] out_vertex,
  output logic [mcs_pkg::CNT_W-1:0] out_size,
  output logic                     out_last
);
  import mcs_pkg::*;

  localparam int NV = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
  localparam int AW = $clog2(NV);
  localparam int DW = $clog2(NV + 1);

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] used_n;
  logic [ROW_W:0]   all_wide;
  logic [ROW_W-1:0] all_mask;

  logic [ROW_W-1:0] row_mem [NV];
  logic [ROW_W-1:0] row_q;
  mcs_frame_t       stk_mem [NV];
  mcs_frame_t       stk_q;

  logic [ROW_W-1:0] rem;
  logic [ROW_W-1:0] rem_after;
  logic [ROW_W-1:0] members;
  logic [ROW_W-1:0] best;
  logic [DW-1:0]    depth;
  logic [DW-1:0]    depth_m1;
  logic [DW-1:0]    best_size;
  logic [ROW_W-1:0] emit_mask;

  logic [IDX_W-1:0] pick;
  logic [ROW_W-1:0] pick_bit;
  logic             row_in_range;

  // Clamp the vertex count to 1..NV and build the initial candidate set
  always_comb begin
    if (vertex_count == '0) begin
      used_n = CNT_W'(1);
    end else if (vertex_count > CNT_W'(NV)) begin
      used_n = CNT_W'(NV);
    end else begin
      used_n = vertex_count;
    end
    all_wide = ((ROW_W + 1)'(1) << used_n) - (ROW_W + 1)'(1);
    all_mask = all_wide[ROW_W-1:0];
  end

  assign pick         = lowest_bit(rem);
  assign pick_bit     = ROW_W'(1) << pick;
  assign depth_m1     = depth - DW'(1);
  assign row_in_range = ({1'b0, in_row_index} < (IDX_W + 1)'(NV));

  assign status.has_cand  = (rem != '0);
  assign status.at_root   = (depth == '0);
  assign status.emit_last = ((emit_mask & (emit_mask - ROW_W'(1))) == '0);

  assign out_vertex = lowest_bit(emit_mask);
  assign out_size   = CNT_W'(best_size);
  assign out_last   = status.emit_last;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(ROW_SLOTS);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  // Adjacency rows: write on load, registered read of the picked vertex
  always_ff @(posedge clk) begin
    if (ctrl.load_row && row_in_range) begin
      row_mem[in_row_index[AW-1:0]] <= in_row_bits;
    end
    row_q <= row_mem[pick[AW-1:0]];
  end

  // Level stack: push on descent, registered read of the parent level
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk_mem[depth[AW-1:0]] <= '{vertex: pick, mask: rem & ~pick_bit};
    end
    stk_q <= stk_mem[depth_m1[AW-1:0]];
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      best_size <= '0;
      members   <= '0;
      best      <= '0;
    end else begin
      if (ctrl.start) begin
        rem       <= all_mask;
        members   <= '0;
        depth     <= '0;
        best      <= '0;
        best_size <= '0;
      end
      // keep the first strictly larger clique
      if (ctrl.eval && (depth > best_size)) begin
        best      <= members;
        best_size <= depth;
      end
      if (ctrl.push) begin
        rem_after <= rem & ~pick_bit;
        members   <= members | pick_bit;
        depth     <= depth + DW'(1);
      end
      if (ctrl.back) begin
        depth <= depth_m1;
      end
      if (ctrl.descend) begin
        rem <= rem_after & row_q;
      end
      if (ctrl.restore) begin
        rem     <= stk_q.mask;
        members <= members & ~(ROW_W'(1) << stk_q.vertex);
      end
    end
  end

  // Result register: drop the lowest member on each taken item
  always_ff @(posedge clk) begin
    if (ctrl.emit_load) begin
      emit_mask <= best;
    end else if (ctrl.emit_take) begin
      emit_mask <= emit_mask & (emit_mask - ROW_W'(1));
    end
  end

endmodule

// ===== hdl/mcs_control.sv =====
// Controller of the maximum clique search: sequences loads, the backtracking
// walk and the shift-out of the best clique.
// Depends on mcs_pkg.
module mcs_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mcs_pkg::mcs_status_t status,
  output mcs_pkg::mcs_ctrl_t   ctrl
);
  import mcs_pkg::*;

  mcs_state_t state;
  mcs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (in_cmd == CMD_RUN)) state_next = S_STEP;
      end
      S_STEP: begin
        priority if (status.has_cand) state_next = S_DESCEND;
        else if (status.at_root)      state_next = S_EMIT;
        else                          state_next = S_RESTORE;
      end
      S_DESCEND: state_next = S_STEP;
      S_RESTORE: state_next = S_STEP;
      S_EMIT: begin
        if (out_ready && status.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl      = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        ctrl.load_row = in_valid && (in_cmd == CMD_LOAD);
        ctrl.start    = in_valid && (in_cmd == CMD_RUN);
      end
      S_STEP: begin
        ctrl.eval      = 1'b1;
        ctrl.push      = status.has_cand;
        ctrl.back      = !status.has_cand && !status.at_root;
        ctrl.emit_load = !status.has_cand && status.at_root;
      end
      S_DESCEND: ctrl.descend = 1'b1;
      S_RESTORE: ctrl.restore = 1'b1;
      S_EMIT: begin
        out_valid      = 1'b1;
        ctrl.emit_take = out_ready;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

// ===== hdl/max_clique_search.sv =====
// Top level of the maximum clique search block: stream ports, configuration
// register port, controller and datapath.
// Depends on mcs_pkg, mcs_control and mcs_datapath.
//
// Usage: an input item with s_axis_tuser low loads one adjacency row
// (row_index, row_bits), so rows stream in at one per cycle while idle. An
// item with s_axis_tuser high starts an exhaustive backtracking search over
// the first vertex_count vertices (clamped to 1..MAX_VERTICES, at most 32);
// no item is taken until all results of that search have been delivered.
// Each descent into a vertex passes S_STEP then S_DESCEND, and each step back
// S_STEP then S_RESTORE, because the row memory and the level stack memory
// have registered reads. The members of the largest clique (first found on
// ties) then leave in ascending order, one item per cycle while m_axis_tready
// is high, each with the clique size and tlast on the final member. A stall
// on the output holds the current item. vertex_count must be written through
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
// Reset sets vertex_count to 32 and returns to idle; adjacency rows hold no
// reset value and must be loaded before a search reads them.
module max_clique_search #(
  parameter int MAX_VERTICES = mcs_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row_index[4:0], row_bits[36:5], zero fill
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // vertex_index[4:0], clique_size[10:5], zero fill
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data
);
  import mcs_pkg::*;

  mcs_ctrl_t        ctrl;
  mcs_status_t      status;
  logic [IDX_W-1:0] out_vertex;
  logic [CNT_W-1:0] out_size;

  mcs_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .ctrl      (ctrl)
  );

  mcs_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_row_index (s_axis_tdata[IDX_W-1:0]),
    .in_row_bits  (s_axis_tdata[IDX_W+ROW_W-1:IDX_W]),
    .out_vertex   (out_vertex),
    .out_size     (out_size),
    .out_last     (m_axis_tlast)
  );

  // Pack the result item
  assign m_axis_tdata = {5'b0, out_size, out_vertex};

endmodule
